>>> sv/jst_pkg.sv
package jst_pkg;

    localparam int QW = 48;
    localparam int SW = 47;
    localparam int CW = 17;
    localparam int AW = 50;
    localparam int NC = 4;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_SENS = 2'd1;
    localparam logic [1:0] OP_LAP  = 2'd2;
    localparam logic [1:0] OP_FLUX = 2'd3;

    localparam logic [0:0] CFG_EPS2 = 1'b0;
    localparam logic [0:0] CFG_EPS4 = 1'b1;

    typedef struct packed {
        logic [1:0]             op;
        logic                   last;
        logic [SW-1:0]          face_lambda;
        logic [SW-1:0]          neighbor_scalar;
        logic signed [QW-1:0]   nq0;
        logic signed [QW-1:0]   nq1;
        logic signed [QW-1:0]   nq2;
        logic signed [QW-1:0]   nq3;
        logic signed [QW-1:0]   nl0;
        logic signed [QW-1:0]   nl1;
        logic signed [QW-1:0]   nl2;
        logic signed [QW-1:0]   nl3;
    } t_in;

    typedef struct packed {
        logic [1:0]             kind;
        logic [CW-1:0]          sensor_y;
        logic signed [QW-1:0]   d0;
        logic signed [QW-1:0]   d1;
        logic signed [QW-1:0]   d2;
        logic signed [QW-1:0]   d3;
    } t_out;

    // saturate a wider signed value into 48 bits
    function automatic logic signed [QW-1:0] sat48(input logic signed [QW+1:0] v);
        logic signed [QW+1:0] mx;
        logic signed [QW+1:0] mn;
        mx = {3'b000, {(QW-1){1'b1}}};
        mn = {3'b111, {(QW-1){1'b0}}};
        if (v > mx) return mx[QW-1:0];
        if (v < mn) return mn[QW-1:0];
        return v[QW-1:0];
    endfunction

endpackage

>>> sv/jst_artificial_dissipation_top.sv
// JST artificial dissipation, one cell at a time. Send an op-0 load, then the
// present neighbors in one mode, with last set on the final item. Inputs go
// into a two-entry queue; the back end finishes one item before it pops the
// next, and a flux item with nonzero lambda runs a multiply loop (three 48x17
// partial products and one accumulate per term, two terms per component).
// A sensor result goes through a bit-serial restoring divide.
// Results are held in an output register until taken; the back end takes no
// new request while a result waits.
module jst_artificial_dissipation_top
    import jst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [CW-1:0] i_cfg_data
);
    logic [CW-1:0] r_eps2, r_eps4;
    logic w_full, w_empty, w_pop;
    t_in  w_q;

    assign o_cfg_ready = 1'b1;
    assign o_stall = w_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps2 <= 17'd32768;
            r_eps4 <= 17'd2048;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_EPS2) r_eps2 <= i_cfg_data;
            else r_eps4 <= i_cfg_data;
        end
    end

    jst_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_valid && !w_full), .i_data(i_data), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_data(w_q)
    );

    jst_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_eps2(r_eps2), .i_eps4(r_eps4),
        .i_empty(w_empty), .i_item(w_q), .o_pop(w_pop),
        .o_valid(o_valid), .i_stall(i_stall), .o_res(o_data)
    );
endmodule

>>> sv/jst_fifo.sv
module jst_fifo
    import jst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_in  i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_in  o_data
);
    // two-entry queue between front and back
    t_in        r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

>>> sv/jst_back.sv
module jst_back
    import jst_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [CW-1:0] i_eps2,
    input  logic [CW-1:0] i_eps4,
    input  logic          i_empty,
    input  t_in           i_item,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output t_out          o_res
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_COEF = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    localparam logic [CW-1:0] ONE = 17'h10000;
    localparam logic [80:0] TLIM = {33'd0, 1'b1, 47'd0};
    localparam logic signed [QW+1:0] TMAX = {3'b000, {(QW-1){1'b1}}};
    localparam logic signed [QW+1:0] TMIN = {3'b111, {(QW-1){1'b0}}};

    t_state r_st;
    t_in    r_it;
    logic [1:0] r_mode;
    logic [SW-1:0] r_own;
    logic signed [QW-1:0] r_cons [NC];
    logic signed [QW-1:0] r_lap  [NC];
    logic signed [QW-1:0] r_acc  [NC];
    logic [AW-1:0] r_up, r_dn;
    logic [CW-1:0] r_e2, r_e4;
    logic [QW-1:0] r_c2, r_c4;
    logic [1:0]    r_j;
    logic          r_sel;
    logic [1:0]    r_dg;
    logic [96:0]   r_p;
    logic [66:0]   r_rem;
    logic [66:0]   r_q;
    logic [6:0]    r_k;
    t_out          r_res;

    logic signed [QW-1:0] w_nq [NC];
    logic signed [QW-1:0] w_nl [NC];
    assign w_nq[0] = r_it.nq0; assign w_nq[1] = r_it.nq1;
    assign w_nq[2] = r_it.nq2; assign w_nq[3] = r_it.nq3;
    assign w_nl[0] = r_it.nl0; assign w_nl[1] = r_it.nl1;
    assign w_nl[2] = r_it.nl2; assign w_nl[3] = r_it.nl3;

    assign o_pop   = (r_st == S_IDLE) && !i_empty;
    assign o_valid = (r_st == S_OUT);
    assign o_res   = r_res;

    // result kind: a load reports the mode of the latest neighbor
    logic [1:0] w_kind;
    assign w_kind = (r_it.op != OP_LOAD) ? r_it.op - 2'd1 :
                    (r_mode == OP_LOAD) ? 2'd0 : r_mode - 2'd1;

    // coefficient products
    logic [CW-1:0] w_yc, w_yn, w_ym;
    logic [33:0]   w_e2p;
    logic [CW-1:0] w_e2;
    assign w_yc = (r_own > SW'(ONE)) ? ONE : r_own[CW-1:0];
    assign w_yn = (r_it.neighbor_scalar > SW'(ONE)) ? ONE : r_it.neighbor_scalar[CW-1:0];
    assign w_ym = (w_yc > w_yn) ? w_yc : w_yn;
    assign w_e2p = i_eps2 * w_ym;
    assign w_e2 = w_e2p[32:16];

    logic [63:0] w_c2p, w_c4p;
    assign w_c2p = r_it.face_lambda * r_e2;
    assign w_c4p = r_it.face_lambda * r_e4;

    // differences for the current component
    logic signed [QW:0] w_dqs, w_dls;
    assign w_dqs = $signed({w_nq[r_j][QW-1], w_nq[r_j]}) - $signed({r_cons[r_j][QW-1], r_cons[r_j]});
    assign w_dls = $signed({r_lap[r_j][QW-1], r_lap[r_j]}) - $signed({w_nl[r_j][QW-1], w_nl[r_j]});

    // scaled term: one 48x17 partial product a cycle, three digits per term
    logic [QW-1:0]      w_cf;
    logic signed [QW:0] w_df;
    logic [50:0]        w_mag;
    logic [16:0]        w_dig;
    logic [64:0]        w_pp;
    logic [96:0]        w_pps;
    assign w_cf  = r_sel ? r_c4 : r_c2;
    assign w_df  = r_sel ? w_dls : w_dqs;
    assign w_mag = {2'b00, (w_df[QW] ? -w_df : w_df)};
    assign w_pp  = w_cf * w_dig;

    always_comb begin
        unique case (r_dg)
            2'd0: begin
                w_dig = w_mag[16:0];
                w_pps = {32'd0, w_pp};
            end
            2'd1: begin
                w_dig = w_mag[33:17];
                w_pps = {15'd0, w_pp, 17'd0};
            end
            2'd2: begin
                w_dig = w_mag[50:34];
                w_pps = {w_pp[62:0], 34'd0};
            end
            2'd3: begin
                w_dig = '0;
                w_pps = '0;
            end
        endcase
    end

    // drop the fraction, truncate toward zero, saturate to 48 bits
    logic [80:0]          w_r;
    logic signed [QW+1:0] w_tm;
    logic signed [QW-1:0] w_acc_n;
    assign w_r = r_p[96:16];

    always_comb begin
        priority if (w_r > TLIM) w_tm = w_df[QW] ? TMIN : TMAX;
        else if (w_df[QW]) w_tm = -$signed({2'b00, w_r[QW-1:0]});
        else if (w_r == TLIM) w_tm = TMAX;
        else w_tm = $signed({2'b00, w_r[QW-1:0]});
    end

    assign w_acc_n = sat48($signed({{2{r_acc[r_j][QW-1]}}, r_acc[r_j]}) + w_tm);

    logic [AW:0] w_abs, w_sum;
    assign w_abs = (r_it.neighbor_scalar > r_own) ? (AW+1)'(r_it.neighbor_scalar - r_own)
                                                  : (AW+1)'(r_own - r_it.neighbor_scalar);
    assign w_sum = (AW+1)'(r_it.neighbor_scalar) + (AW+1)'(r_own);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_mode <= OP_LOAD;
            r_own <= '0;
            r_up <= '0;
            r_dn <= '0;
            for (int j = 0; j < NC; j++) begin
                r_cons[j] <= '0; r_lap[j] <= '0; r_acc[j] <= '0;
            end
        end else begin
            unique case (r_st)
                S_IDLE: if (!i_empty) begin
                    r_it <= i_item;
                    r_st <= S_COEF;
                end
                S_COEF: begin
                    r_j <= 2'd0;
                    r_res <= {w_kind, {(CW + NC*QW){1'b0}}};
                    if (r_it.op == OP_LOAD) begin
                        r_own <= r_it.neighbor_scalar;
                        r_cons[0] <= r_it.nq0; r_cons[1] <= r_it.nq1;
                        r_cons[2] <= r_it.nq2; r_cons[3] <= r_it.nq3;
                        r_lap[0] <= r_it.nl0; r_lap[1] <= r_it.nl1;
                        r_lap[2] <= r_it.nl2; r_lap[3] <= r_it.nl3;
                        for (int j = 0; j < NC; j++) r_acc[j] <= '0;
                        r_up <= '0; r_dn <= '0;
                        r_st <= r_it.last ? S_OUT : S_IDLE;
                    end else begin
                        r_mode <= r_it.op;
                        r_e2 <= w_e2;
                        r_e4 <= (i_eps4 > w_e2) ? i_eps4 - w_e2 : '0;
                        priority if (r_it.op == OP_SENS) begin
                            r_up <= (w_abs + r_up > {1'b0, {AW{1'b1}}}) ? {AW{1'b1}}
                                    : AW'(w_abs + r_up);
                            r_dn <= (w_sum + r_dn > {1'b0, {AW{1'b1}}}) ? {AW{1'b1}}
                                    : AW'(w_sum + r_dn);
                            r_st <= S_DIV;
                        end else if (r_it.op == OP_LAP) begin
                            for (int j = 0; j < NC; j++)
                                r_acc[j] <= sat48($signed({{2{r_acc[j][QW-1]}}, r_acc[j]})
                                    + $signed({w_nq[j][QW-1], w_nq[j][QW-1], w_nq[j]})
                                    - $signed({r_cons[j][QW-1], r_cons[j][QW-1], r_cons[j]}));
                            r_st <= S_DIV;
                        end else begin
                            r_st <= (r_it.face_lambda == '0) ? S_DIV : S_MUL;
                        end
                        r_k <= 7'd0;
                    end
                end
                S_MUL: begin
                    // eps2 term then eps4 term for each component in turn
                    if (r_k == 7'd0) begin
                        r_c2 <= w_c2p[63:16];
                        r_c4 <= w_c4p[63:16];
                        r_sel <= 1'b0;
                        r_dg <= 2'd0;
                        r_p <= '0;
                        r_k <= 7'd1;
                    end else if (r_dg != 2'd3) begin
                        r_p <= r_p + w_pps;
                        r_dg <= r_dg + 2'd1;
                    end else begin
                        r_acc[r_j] <= w_acc_n;
                        r_p <= '0;
                        r_dg <= 2'd0;
                        r_sel <= ~r_sel;
                        if (r_sel) begin
                            r_j <= r_j + 2'd1;
                            if (r_j == 2'(NC-1)) r_st <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    // release the result; restoring divide for the sensor result, one bit a cycle
                    if (!r_it.last) r_st <= S_IDLE;
                    else if (r_it.op != OP_SENS) begin
                        r_res.d0 <= r_acc[0]; r_res.d1 <= r_acc[1];
                        r_res.d2 <= r_acc[2]; r_res.d3 <= r_acc[3];
                        r_st <= S_OUT;
                    end else if (r_dn == '0) begin
                        r_st <= S_OUT;
                    end else if (r_k == 7'd0) begin
                        r_q <= {r_up, 17'd0};
                        r_rem <= '0;
                        r_k <= 7'd1;
                    end else if (r_k <= 7'd67) begin
                        logic [67:0] t;
                        t = {r_rem, r_q[66]};
                        if (t >= 68'(r_dn)) begin
                            r_rem <= 67'(t - 68'(r_dn));
                            r_q <= {r_q[65:0], 1'b1};
                        end else begin
                            r_rem <= t[66:0];
                            r_q <= {r_q[65:0], 1'b0};
                        end
                        r_k <= r_k + 7'd1;
                    end else begin
                        r_res.sensor_y <= (r_q[66:1] > 66'(ONE)) ? ONE : r_q[CW:1];
                        r_st <= S_OUT;
                    end
                end
                S_OUT: if (!i_stall) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // back end only pops while idle, and holds a result until taken
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_st == S_IDLE) else $error("pop outside idle");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(r_res)) else $error("result lost");
    a_no_pop_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_pop) else $error("pop while result pending");
endmodule

>>> dv/jst_dissipation_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and register channels, predicts each cell's
// result and compares it with what the block delivers.
module jst_dissipation_checker
    import jst_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_stall_in,
    input  t_in           i_data,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  t_out          i_out_data,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_ready,
    input  logic          i_cfg_index,
    input  logic [CW-1:0] i_cfg_data,
    output int            o_pending,
    output int            o_errors
);

    localparam logic signed [QW+3:0] MAXQ = (52'sd1 <<< (QW-1)) - 1;
    localparam logic signed [QW+3:0] MINQ = -(52'sd1 <<< (QW-1));
    localparam logic [AW-1:0] SUM_MAX = {AW{1'b1}};
    localparam logic [CW-1:0] ONE_Q = 17'd65536;

    // predictor state
    logic [CW-1:0]          k2;
    logic [CW-1:0]          k4;
    logic [1:0]             last_mode;
    logic [SW-1:0]          own_p;
    logic signed [QW-1:0]   own_q [NC];
    logic signed [QW-1:0]   own_l [NC];
    logic [AW-1:0]          up_sum;
    logic [AW-1:0]          down_sum;
    logic signed [QW-1:0]   acc [NC];
    t_out                   cell_results [$];
    int                     errors;

    assign o_pending = cell_results.size();
    assign o_errors  = errors;

    function automatic logic signed [QW-1:0] clamp48(input logic signed [QW+3:0] v);
        if (v > MAXQ) return MAXQ[QW-1:0];
        if (v < MINQ) return MINQ[QW-1:0];
        return v[QW-1:0];
    endfunction

    function automatic logic [AW-1:0] add_sat50(input logic [AW-1:0] a,
                                                input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[AW] ? SUM_MAX : s[AW-1:0];
    endfunction

    // coef * diff / 2^16, truncated toward zero, saturated to 48 bits
    function automatic logic signed [QW+3:0] scale_term(input logic [63:0] coef,
                                                        input logic signed [QW+3:0] diff);
        logic [127:0] mag;
        logic [127:0] r;
        mag = (diff < 0) ? 128'(-diff) : 128'(diff);
        r = (128'(coef) * mag) >> 16;
        if (r > (128'd1 << (QW-1))) return (diff < 0) ? MINQ : MAXQ;
        if (diff < 0) return -$signed(52'(r));
        if (r == (128'd1 << (QW-1))) return MAXQ;
        return $signed(52'(r));
    endfunction

    function automatic logic [CW-1:0] sensor_ratio(input logic [AW-1:0] u,
                                                   input logic [AW-1:0] d);
        logic [127:0] q;
        if (d == '0) return '0;
        q = (128'(u) << 16) / 128'(d);
        return (q > 128'(ONE_Q)) ? ONE_Q : q[CW-1:0];
    endfunction

    task automatic predict_cell(input t_in r);
        logic signed [QW-1:0] nq [NC];
        logic signed [QW-1:0] nl [NC];
        logic [63:0] yc, yn, ym, e2, e4, c2, c4;
        logic signed [QW+3:0] t;
        t_out res;
        nq = '{r.nq0, r.nq1, r.nq2, r.nq3};
        nl = '{r.nl0, r.nl1, r.nl2, r.nl3};
        res = '0;
        if (r.op == OP_LOAD) begin
            own_p = r.neighbor_scalar;
            for (int j = 0; j < NC; j++) begin
                own_q[j] = nq[j];
                own_l[j] = nl[j];
                acc[j] = '0;
            end
            up_sum = '0;
            down_sum = '0;
            if (r.last) begin
                res.kind = (last_mode == OP_LOAD) ? 2'd0 : last_mode - 2'd1;
                cell_results.push_back(res);
            end
            return;
        end
        last_mode = r.op;
        if (r.op == OP_SENS) begin
            up_sum = add_sat50(up_sum, (r.neighbor_scalar > own_p) ?
                               AW'(r.neighbor_scalar - own_p) : AW'(own_p - r.neighbor_scalar));
            down_sum = add_sat50(down_sum, AW'(r.neighbor_scalar) + AW'(own_p));
        end else if (r.op == OP_LAP) begin
            for (int j = 0; j < NC; j++)
                acc[j] = clamp48(52'(acc[j]) + 52'(nq[j]) - 52'(own_q[j]));
        end else if (r.face_lambda != '0) begin
            yc = (own_p > SW'(ONE_Q)) ? 64'(ONE_Q) : 64'(own_p);
            yn = (r.neighbor_scalar > SW'(ONE_Q)) ? 64'(ONE_Q) : 64'(r.neighbor_scalar);
            ym = (yc > yn) ? yc : yn;
            e2 = (64'(k2) * ym) >> 16;
            e4 = (64'(k4) > e2) ? 64'(k4) - e2 : 64'd0;
            c2 = (64'(r.face_lambda) * e2) >> 16;
            c4 = (64'(r.face_lambda) * e4) >> 16;
            for (int j = 0; j < NC; j++) begin
                t = scale_term(c2, 52'(nq[j]) - 52'(own_q[j]));
                acc[j] = clamp48(52'(acc[j]) + t);
                t = scale_term(c4, 52'(own_l[j]) - 52'(nl[j]));
                acc[j] = clamp48(52'(acc[j]) + t);
            end
        end
        if (!r.last) return;
        res.kind = r.op - 2'd1;
        if (r.op == OP_SENS) begin
            res.sensor_y = sensor_ratio(up_sum, down_sum);
        end else begin
            res.d0 = acc[0];
            res.d1 = acc[1];
            res.d2 = acc[2];
            res.d3 = acc[3];
        end
        cell_results.push_back(res);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            k2 = 17'd32768;
            k4 = 17'd2048;
            last_mode = OP_LOAD;
            own_p = '0;
            up_sum = '0;
            down_sum = '0;
            for (int j = 0; j < NC; j++) begin
                own_q[j] = '0;
                own_l[j] = '0;
                acc[j] = '0;
            end
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_EPS2) k2 = i_cfg_data;
                else k4 = i_cfg_data;
            end
            if (i_valid && !i_stall_in) predict_cell(i_data);
        end
    end

    // compare each delivered result with the oldest prediction
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (cell_results.size() == 0) begin
                errors <= errors + 1;
                $display("%0t: unexpected result %h", $time, i_out_data);
            end else begin
                want = cell_results.pop_front();
                if (want !== i_out_data) begin
                    errors <= errors + 1;
                    $display("%0t: mismatch expected kind=%0d y=%h d=%h %h %h %h",
                             $time, want.kind, want.sensor_y, want.d0, want.d1,
                             want.d2, want.d3);
                    $display("%0t:          actual   kind=%0d y=%h d=%h %h %h %h",
                             $time, i_out_data.kind, i_out_data.sensor_y, i_out_data.d0,
                             i_out_data.d1, i_out_data.d2, i_out_data.d3);
                end
            end
        end
    end

    initial errors = 0;

endmodule

>>> dv/tb_jst_artificial_dissipation_top.sv
`timescale 1ns / 1ps

module tb_jst_artificial_dissipation_top;
    import jst_pkg::*;

    localparam int DRAIN_CYCLES = 150;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    t_in           i_data;
    logic          o_valid;
    logic          i_stall;
    t_out          o_data;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic          i_cfg_index;
    logic [CW-1:0] i_cfg_data;
    int            pending;
    int            errors;
    bit            in_burst;
    bit            out_burst;
    int            hold_cnt;

    jst_artificial_dissipation_top dut (.*);

    jst_dissipation_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_stall_in(o_stall), .i_data(i_data),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_out_data(o_data),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_pending(pending), .o_errors(errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    // result side back-pressure: a fresh hold per result, bursts without any
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_cnt <= 0;
        end else if (o_valid && !i_stall) begin
            if ($urandom_range(0, 7) == 0) out_burst = ~out_burst;
            hold_cnt <= out_burst ? 0 : $urandom_range(0, 5);
            i_stall <= !out_burst && ($urandom_range(0, 1) == 1);
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_stall <= (hold_cnt > 1);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // conserved value: extremes, zero, small values and full range
    function automatic logic signed [QW-1:0] rand_q();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(QW-1){1'b1}}};
            1: return {1'b1, {(QW-1){1'b0}}};
            2: return '0;
            3, 4, 5: return QW'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
            default: return QW'({$urandom, $urandom});
        endcase
    endfunction

    // unsigned 47-bit scalar, often near the Q1.16 sensor range
    function automatic logic [SW-1:0] rand_s();
        case ($urandom_range(0, 7))
            0: return {SW{1'b1}};
            1: return '0;
            2, 3: return SW'($urandom_range(0, 70000));
            4: return SW'($urandom_range(0, 32'h00FF_FFFF));
            default: return SW'({$urandom, $urandom});
        endcase
    endfunction

    function automatic t_in rand_request(input logic [1:0] op, input logic last);
        t_in r;
        r.op = op;
        r.last = last;
        case ($urandom_range(0, 5))
            0: r.face_lambda = '0;
            1: r.face_lambda = {SW{1'b1}};
            2, 3: r.face_lambda = SW'($urandom_range(0, 32'h000F_FFFF));
            default: r.face_lambda = SW'({$urandom, $urandom});
        endcase
        r.neighbor_scalar = rand_s();
        r.nq0 = rand_q(); r.nq1 = rand_q(); r.nq2 = rand_q(); r.nq3 = rand_q();
        r.nl0 = rand_q(); r.nl1 = rand_q(); r.nl2 = rand_q(); r.nl3 = rand_q();
        return r;
    endfunction

    task automatic send_request(input t_in r);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // wait until the block holds no work before touching its registers
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one cell: own load, then neighbors in one mode, last on the final one
    task automatic run_cell(input logic [1:0] mode, input int n_nb);
        send_request(rand_request(OP_LOAD, 1'b0));
        for (int i = 0; i < n_nb; i++)
            send_request(rand_request(mode, i == n_nb - 1));
    endtask

    task automatic random_phase(input int n_items);
        int sent;
        int n_nb;
        logic [1:0] mode;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) in_burst = ~in_burst;
            case ($urandom_range(0, 11))
                0: begin
                    // stray neighbor or a load that ends a cell with no neighbors
                    send_request(rand_request(2'($urandom_range(0, 3)),
                                              1'($urandom_range(0, 1))));
                    sent += 1;
                end
                1: begin
                    // mixed modes inside one cell
                    n_nb = $urandom_range(2, 5);
                    send_request(rand_request(OP_LOAD, 1'b0));
                    for (int i = 0; i < n_nb; i++)
                        send_request(rand_request(2'($urandom_range(1, 3)), i == n_nb - 1));
                    sent += n_nb + 1;
                end
                default: begin
                    mode = 2'($urandom_range(1, 3));
                    n_nb = $urandom_range(1, 6);
                    run_cell(mode, n_nb);
                    sent += n_nb + 1;
                end
            endcase
        end
    endtask

    initial begin
        t_in r;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_EPS2;
        i_cfg_data = '0;
        in_burst = 1'b0;
        out_burst = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: a load marked last before any neighbor
        send_request(rand_request(OP_LOAD, 1'b1));
        // sensor with all pressures zero gives a zero denominator
        r = '0;
        send_request(r);
        r.op = OP_SENS; r.last = 1'b1;
        send_request(r);
        // sensor at the largest pressures
        r = '0;
        r.neighbor_scalar = {SW{1'b1}};
        send_request(r);
        r.op = OP_SENS;
        send_request(r);
        r.neighbor_scalar = '0; r.last = 1'b1;
        send_request(r);
        // Laplacian pass pushed into both saturation limits
        r = '0;
        r.nq0 = {1'b1, {(QW-1){1'b0}}}; r.nq1 = {1'b0, {(QW-1){1'b1}}};
        send_request(r);
        r.op = OP_LAP;
        r.nq0 = {1'b0, {(QW-1){1'b1}}}; r.nq1 = {1'b1, {(QW-1){1'b0}}};
        send_request(r);
        r.last = 1'b1;
        send_request(r);
        // flux: zero lambda face skipped, then the widest face
        r = '0;
        r.neighbor_scalar = SW'(32768);
        r.nl2 = {1'b0, {(QW-1){1'b1}}};
        send_request(r);
        r.op = OP_FLUX;
        r.nq0 = {1'b1, {(QW-1){1'b0}}};
        send_request(r);
        r.face_lambda = {SW{1'b1}};
        r.neighbor_scalar = {SW{1'b1}};
        r.nl2 = {1'b1, {(QW-1){1'b0}}};
        r.nq3 = {1'b0, {(QW-1){1'b1}}};
        r.last = 1'b1;
        send_request(r);
        // load marked last after a flux pass reports the flux kind
        send_request(rand_request(OP_LOAD, 1'b1));
        // Laplacian then flux in one cell
        send_request(rand_request(OP_LOAD, 1'b0));
        send_request(rand_request(OP_LAP, 1'b0));
        send_request(rand_request(OP_FLUX, 1'b1));

        random_phase(300);

        // coefficient sweeps, extremes first
        wait_idle();
        write_reg(CFG_EPS2, 17'd0);
        write_reg(CFG_EPS4, 17'd0);
        random_phase(200);
        wait_idle();
        write_reg(CFG_EPS2, 17'd65536);
        write_reg(CFG_EPS4, 17'd65536);
        random_phase(250);
        wait_idle();
        write_reg(CFG_EPS2, 17'd0);
        random_phase(250);
        wait_idle();
        write_reg(CFG_EPS2, 17'd65536);
        write_reg(CFG_EPS4, 17'd0);
        random_phase(250);
        for (int p = 0; p < 2; p++) begin
            wait_idle();
            write_reg(CFG_EPS2, CW'($urandom_range(0, 65536)));
            write_reg(CFG_EPS4, CW'($urandom_range(0, 65536)));
            random_phase(250);
        end

        wait_idle();
        if (errors == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
